@@ rtl/sra_pkg.sv @@
// Shared types, constants and reduction functions for the segment reduction accumulator.
// No dependencies; used by segment_reduction_accumulator_top.
`timescale 1ns / 1ps

package sra_pkg;

   localparam int DATA_W      = 32;
   localparam int OPCODE_W    = 2;
   localparam int COLUMN_W    = 4;
   localparam int MODE_W      = 2;
   localparam int SEG_COUNT_W = 9;
   localparam int ROW_WIDTH_W = 5;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 9;
   localparam int EPOCH_W     = 8;

   localparam logic [SEG_COUNT_W-1:0] SEG_COUNT_RESET = 9'd256;
   localparam logic [ROW_WIDTH_W-1:0] ROW_WIDTH_RESET = 5'd16;

   typedef logic [EPOCH_W-1:0] epoch_type;

   // Tag 0 marks an entry as empty; live epochs run from 1 to all ones.
   localparam epoch_type EPOCH_STALE = '0;
   localparam epoch_type EPOCH_FIRST = epoch_type'(1);
   localparam epoch_type EPOCH_LAST  = '1;

   typedef enum logic [OPCODE_W-1:0] {
      OP_CLEAR = 2'd0,
      OP_ACCUM = 2'd1,
      OP_READ  = 2'd2
   } op_type;

   typedef enum logic [MODE_W-1:0] {
      MODE_SUM  = 2'd0,
      MODE_MAX  = 2'd1,
      MODE_MIN  = 2'd2,
      MODE_PROD = 2'd3
   } mode_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MODE      = 2'd0,
      CSR_SEG_COUNT = 2'd1,
      CSR_ROW_WIDTH = 2'd2
   } csr_index_type;

   typedef struct packed {
      epoch_type         tag;
      logic [DATA_W-1:0] data;
   } entry_type;

   function automatic logic [DATA_W-1:0] identity_of(mode_type mode);
      logic [DATA_W-1:0] res;
      case (mode)
         MODE_SUM:  res = '0;
         MODE_MAX:  res = {1'b1, {(DATA_W-1){1'b0}}};
         MODE_MIN:  res = {1'b0, {(DATA_W-1){1'b1}}};
         MODE_PROD: res = DATA_W'(1);
         default:   res = '0;
      endcase
      return res;
   endfunction

   function automatic logic [DATA_W-1:0] combine(mode_type mode, logic [DATA_W-1:0] acc,
                                                 logic [DATA_W-1:0] v);
      logic [DATA_W-1:0] res;
      case (mode)
         MODE_SUM:  res = acc + v;
         MODE_MAX:  res = ($signed(v) > $signed(acc)) ? v : acc;
         MODE_MIN:  res = ($signed(v) < $signed(acc)) ? v : acc;
         MODE_PROD: res = acc * v;
         default:   res = acc;
      endcase
      return res;
   endfunction

endpackage

@@ rtl/segment_reduction_accumulator_top.sv @@
// Segment reduction accumulator: per-segment, per-column sum/max/min/product table.
// Depends on sra_pkg. Holds the table memory, its read-modify-write stage and the CSRs.
//
//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_ready  | opcode, segment_id, column, value
//  rsp     | out       | rsp_valid/rsp_ready  | result_value, empty_res
//  csr     | in        | csr_valid/csr_ready  | index, data (csr_ready always high)
//
// One transaction per cycle unless stalled: the table is read on accept and written back
// in the next cycle, with a one-entry forward covering back-to-back hits on the same entry.
// Clear bumps an epoch tag stored with each entry. After reset, and after every 255th clear,
// a clearing pass rewrites all MAX_SEGMENTS*MAX_COLUMNS tags; req_ready is low then.
// A read stalls in the write-back stage while the response register holds an untaken result.
`timescale 1ns / 1ps

module segment_reduction_accumulator_top #(
   parameter int MAX_SEGMENTS = 256,
   parameter int MAX_COLUMNS  = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [sra_pkg::OPCODE_W-1:0]         req_opcode,
   input  logic signed [sra_pkg::DATA_W-1:0]    req_segment_id,
   input  logic [sra_pkg::COLUMN_W-1:0]         req_column,
   input  logic signed [sra_pkg::DATA_W-1:0]    req_value,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [sra_pkg::DATA_W-1:0]    rsp_result_value,
   output logic                                 rsp_empty_res,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [sra_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [sra_pkg::CSR_DATA_W-1:0]       csr_data
);

   localparam int DEPTH  = MAX_SEGMENTS * MAX_COLUMNS;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int SEG_W  = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

   typedef enum logic [1:0] {
      ST_SWEEP = 2'b01,
      ST_RUN   = 2'b10
   } state_type;

   // CSRs
   sra_pkg::mode_type                   mode_ff;
   logic [sra_pkg::SEG_COUNT_W-1:0]     seg_count_ff;
   logic [sra_pkg::ROW_WIDTH_W-1:0]     row_width_ff;

   // control
   state_type                           state_ff, state_in;
   sra_pkg::epoch_type                  epoch_ff, epoch_in;
   logic [ADDR_W-1:0]                   sweep_addr_ff, sweep_addr_in;

   // write-back stage
   logic                                s1_valid_ff, s1_valid_in;
   sra_pkg::op_type                     s1_op_ff;
   logic                                s1_hit_ff;
   logic [ADDR_W-1:0]                   s1_addr_ff;
   logic [sra_pkg::DATA_W-1:0]          s1_value_ff;
   sra_pkg::entry_type                  rdata_ff;

   // forward of the last write
   logic                                wr_valid_ff, wr_valid_in;
   logic [ADDR_W-1:0]                   wr_addr_ff;
   sra_pkg::entry_type                  wr_entry_ff;

   // response register
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [sra_pkg::DATA_W-1:0]          rsp_value_ff;
   logic                                rsp_empty_ff;

   sra_pkg::entry_type                  mem [DEPTH];

   logic [sra_pkg::DATA_W-1:0] seg_u;
   logic                       seg_ok, col_ok, req_hit, accept;
   logic [ADDR_W-1:0]          req_addr;
   logic                       s1_go, s1_fire, wrap_pending;
   logic                       fwd, old_live, s1_we, rsp_load;
   sra_pkg::entry_type         old_entry, new_entry;
   logic                       mem_we;
   logic [ADDR_W-1:0]          mem_waddr;
   sra_pkg::entry_type         mem_wdata;

   // address decode
   assign seg_u  = req_segment_id;
   assign seg_ok = !seg_u[sra_pkg::DATA_W-1]
                   && (seg_u < sra_pkg::DATA_W'(seg_count_ff))
                   && (seg_u < sra_pkg::DATA_W'(MAX_SEGMENTS));
   assign col_ok = ({1'b0, req_column} < row_width_ff)
                   && (32'(req_column) < 32'(MAX_COLUMNS));
   assign req_hit  = seg_ok && col_ok;
   assign req_addr = ADDR_W'(ADDR_W'(seg_u[SEG_W-1:0]) * ADDR_W'(MAX_COLUMNS)
                             + ADDR_W'(req_column));

   // handshake
   assign s1_go        = (s1_op_ff != sra_pkg::OP_READ) || !rsp_valid_ff || rsp_ready;
   assign s1_fire      = s1_valid_ff && s1_go;
   assign wrap_pending = s1_valid_ff && (s1_op_ff == sra_pkg::OP_CLEAR)
                         && (epoch_ff == sra_pkg::EPOCH_LAST);
   assign req_ready    = (state_ff == ST_RUN) && !wrap_pending && (!s1_valid_ff || s1_go);
   assign accept       = req_valid && req_ready;
   assign csr_ready    = 1'b1;

   // read-modify-write
   assign fwd       = wr_valid_ff && (wr_addr_ff == s1_addr_ff);
   assign old_entry = fwd ? wr_entry_ff : rdata_ff;
   assign old_live  = (old_entry.tag == epoch_ff);
   assign s1_we     = s1_fire && (s1_op_ff == sra_pkg::OP_ACCUM) && s1_hit_ff;
   assign rsp_load  = s1_fire && (s1_op_ff == sra_pkg::OP_READ);

   always_comb begin
      new_entry.tag  = epoch_ff;
      new_entry.data = old_live ? sra_pkg::combine(mode_ff, old_entry.data, s1_value_ff)
                                : s1_value_ff;
   end

   always_comb begin
      if (state_ff == ST_SWEEP) begin
         mem_we         = 1'b1;
         mem_waddr      = sweep_addr_ff;
         mem_wdata.tag  = sra_pkg::EPOCH_STALE;
         mem_wdata.data = '0;
      end else begin
         mem_we    = s1_we;
         mem_waddr = s1_addr_ff;
         mem_wdata = new_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (accept) begin
         rdata_ff <= mem[req_addr];
      end
   end

   // epoch and clearing pass
   always_comb begin
      state_in      = state_ff;
      epoch_in      = epoch_ff;
      sweep_addr_in = sweep_addr_ff;
      case (state_ff)
         ST_SWEEP: begin
            if (sweep_addr_ff == LAST_ADDR) begin
               state_in      = ST_RUN;
               epoch_in      = sra_pkg::EPOCH_FIRST;
               sweep_addr_in = '0;
            end else begin
               sweep_addr_in = sweep_addr_ff + ADDR_W'(1);
            end
         end
         ST_RUN: begin
            if (s1_fire && (s1_op_ff == sra_pkg::OP_CLEAR)) begin
               if (epoch_ff == sra_pkg::EPOCH_LAST) begin
                  state_in = ST_SWEEP;
               end else begin
                  epoch_in = epoch_ff + sra_pkg::EPOCH_FIRST;
               end
            end
         end
         default: begin
            state_in      = ST_SWEEP;
            sweep_addr_in = '0;
         end
      endcase
   end

   always_comb begin
      s1_valid_in = accept ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_ff);
      wr_valid_in = (!s1_valid_ff || s1_fire) ? s1_we : wr_valid_ff;
      rsp_valid_in = rsp_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_SWEEP;
         epoch_ff      <= sra_pkg::EPOCH_FIRST;
         sweep_addr_ff <= '0;
         s1_valid_ff   <= 1'b0;
         wr_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         mode_ff       <= sra_pkg::MODE_SUM;
         seg_count_ff  <= sra_pkg::SEG_COUNT_RESET;
         row_width_ff  <= sra_pkg::ROW_WIDTH_RESET;
      end else begin
         state_ff      <= state_in;
         epoch_ff      <= epoch_in;
         sweep_addr_ff <= sweep_addr_in;
         s1_valid_ff   <= s1_valid_in;
         wr_valid_ff   <= wr_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            case (sra_pkg::csr_index_type'(csr_index))
               sra_pkg::CSR_MODE:
                  mode_ff <= sra_pkg::mode_type'(csr_data[sra_pkg::MODE_W-1:0]);
               sra_pkg::CSR_SEG_COUNT:
                  seg_count_ff <= csr_data[sra_pkg::SEG_COUNT_W-1:0];
               sra_pkg::CSR_ROW_WIDTH:
                  row_width_ff <= csr_data[sra_pkg::ROW_WIDTH_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_op_ff    <= sra_pkg::op_type'(req_opcode);
         s1_hit_ff   <= req_hit;
         s1_addr_ff  <= req_addr;
         s1_value_ff <= req_value;
      end
      if (s1_we) begin
         wr_addr_ff  <= s1_addr_ff;
         wr_entry_ff <= new_entry;
      end
      if (rsp_load) begin
         if (s1_hit_ff && old_live) begin
            rsp_value_ff <= old_entry.data;
            rsp_empty_ff <= 1'b0;
         end else begin
            rsp_value_ff <= sra_pkg::identity_of(mode_ff);
            rsp_empty_ff <= 1'b1;
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_empty_res    = rsp_empty_ff;

endmodule
